[hdl/vsg_pkg.sv]
// vsg_pkg: shared types and constants for the voxel store / central gradient core.
// No dependencies; imported by vsg_ram and voxel_store_central_gradient_core.
package vsg_pkg;

  // Default sizing
  localparam int DEFAULT_MAX_DIM     = 64;
  localparam int DEFAULT_VOXEL_DEPTH = 262144;

  // Field widths
  localparam int VOXEL_W = 8;
  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;
  localparam int GRAD_W  = 9;

  // Linear address arithmetic: x + nx*(y + ny*z) and its neighbours fit in 21 bits
  localparam int YZ_W    = 13;
  localparam int PLANE_W = 14;
  localparam int LIN_W   = 21;

  // Register file
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Order in which a query visits the memory
  typedef enum logic [2:0] {
    RD_CENTRE,
    RD_XP,
    RD_XM,
    RD_YP,
    RD_YM,
    RD_ZP,
    RD_ZM
  } slot_t;

endpackage

[hdl/vsg_ram.sv]
// vsg_ram: single-port synchronous voxel memory with a registered read.
// Depends on vsg_pkg for default sizing.
module vsg_ram
  import vsg_pkg::*;
#(
  parameter int DEPTH = DEFAULT_VOXEL_DEPTH,
  parameter int AW    = $clog2(DEFAULT_VOXEL_DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      addr,
  input  logic [VOXEL_W-1:0] wdata,
  output logic [VOXEL_W-1:0] rdata
);

  logic [VOXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/voxel_store_central_gradient_core.sv]
// voxel_store_central_gradient_core: top level of the voxel store with
// central-difference gradient queries. Depends on vsg_pkg and vsg_ram.
//
// Usage
//   Input stream (s_*): one item per handshake. s_tuser selects the kind:
//   write (store voxel_in at the point) or query. Writes give no result.
//   Output stream (m_*): one item per query: voxel, gradient on each axis,
//   and the inside / interior flags.
//   APB port: size_x, size_y, size_z at byte addresses 0, 4, 8. Change them
//   only while the core is idle. Sizes above MAX_DIM act as MAX_DIM.
// Sequence (acceptance to the earliest next acceptance)
//   A write inside the volume passes the address multiply, then the
//   memory write; an ignored write only the multiply. A query passes the
//   multiply, then one memory read per slot (centre and six neighbours
//   for an interior point, the centre alone on the border), a drain and
//   done; a point outside goes from the multiply straight to done. Its
//   result is valid in the cycle the core is ready again. The single
//   memory port, one read per cycle, sets the query rate.
// Reset
//   rst (synchronous) empties the pipeline and returns the sizes to 64.
//   The voxel memory is not cleared: load every voxel before querying.
// Back-pressure
//   A finished result sits in the output register; the next item is
//   accepted meanwhile and the core holds only if a second result is
//   ready before the first has been taken.
module voxel_store_central_gradient_core
  import vsg_pkg::*;
#(
  parameter int MAX_DIM     = DEFAULT_MAX_DIM,
  parameter int VOXEL_DEPTH = DEFAULT_VOXEL_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // coord_x[5:0], coord_y[11:6], coord_z[17:12],
                                           // voxel_in[25:18], zero above
  input  logic                  s_tuser,   // func
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // voxel_out[7:0], grad_x[16:8], grad_y[25:17],
                                           // grad_z[34:26], zero above
  output logic [1:0]            m_tuser,   // inside_res[0], interior[1]
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(VOXEL_DEPTH);
  localparam logic [8:0] MaxDimW = 9'(MAX_DIM);

  // ---------------------------------------------------------------- registers
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SIZE_X: size_x <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y: size_y <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z: size_z <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = APB_DATA_W'(size_x);
      REG_SIZE_Y: prdata = APB_DATA_W'(size_y);
      REG_SIZE_Z: prdata = APB_DATA_W'(size_z);
      default:    prdata = '0;
    endcase
  end

  // Saturate at MAX_DIM
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    return ({2'b00, s} > MaxDimW) ? SIZE_W'(MAX_DIM) : s;
  endfunction

  logic [SIZE_W-1:0] nx, ny, nz;
  assign nx = eff_size(size_x);
  assign ny = eff_size(size_y);
  assign nz = eff_size(size_z);

  // ---------------------------------------------------------------- input decode
  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic [VOXEL_W-1:0] in_vox;
  logic               in_inside, in_interior;
  logic [YZ_W-1:0]    yz_next;
  logic [PLANE_W-1:0] plane_next;

  assign in_x   = s_tdata[5:0];
  assign in_y   = s_tdata[11:6];
  assign in_z   = s_tdata[17:12];
  assign in_vox = s_tdata[25:18];

  assign in_inside = ({1'b0, in_x} < nx) && ({1'b0, in_y} < ny) && ({1'b0, in_z} < nz);
  assign in_interior = (in_x != '0) && (in_y != '0) && (in_z != '0) &&
                       ({1'b0, in_x} + 7'd1 < nx) &&
                       ({1'b0, in_y} + 7'd1 < ny) &&
                       ({1'b0, in_z} + 7'd1 < nz);

  // First half of the address: y + ny*z, and the z stride nx*ny
  assign yz_next    = YZ_W'(YZ_W'(ny) * YZ_W'(in_z)) + YZ_W'(in_y);
  assign plane_next = PLANE_W'(PLANE_W'(nx) * PLANE_W'(ny));

  // ---------------------------------------------------------------- item registers
  state_t             state, state_next;
  slot_t              rd_slot, rd_slot_next;
  logic               func_q, inside_q, interior_q;
  logic [COORD_W-1:0] x_q;
  logic [VOXEL_W-1:0] vox_q;
  logic [YZ_W-1:0]    yz_q;
  logic [PLANE_W-1:0] plane_q;
  logic [LIN_W-1:0]   base_q, base_next;
  logic               accept;

  assign accept    = s_tvalid && s_tready;
  assign base_next = LIN_W'(nx) * LIN_W'(yz_q) + LIN_W'(x_q);

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q     <= s_tuser;
      inside_q   <= in_inside;
      interior_q <= in_interior;
      x_q        <= in_x;
      vox_q      <= in_vox;
      yz_q       <= yz_next;
      plane_q    <= plane_next;
    end
    if (state == ST_MUL) begin
      base_q <= base_next;
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic last_slot, out_free, load_out, rd_issue, ram_we;

  assign last_slot = (rd_slot == RD_ZM) || ((rd_slot == RD_CENTRE) && !interior_q);
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_MUL;
      ST_MUL: begin
        if (func_q == FUNC_WRITE) begin
          state_next = inside_q ? ST_WRITE : ST_IDLE;
        end else begin
          state_next = inside_q ? ST_READ : ST_DONE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_READ:  if (last_slot) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    rd_issue = (state == ST_READ);
    load_out = (state == ST_DONE) && out_free;
  end

  always_comb begin
    case (rd_slot)
      RD_CENTRE: rd_slot_next = RD_XP;
      RD_XP:     rd_slot_next = RD_XM;
      RD_XM:     rd_slot_next = RD_YP;
      RD_YP:     rd_slot_next = RD_YM;
      RD_YM:     rd_slot_next = RD_ZP;
      RD_ZP:     rd_slot_next = RD_ZM;
      default:   rd_slot_next = RD_CENTRE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_slot <= RD_CENTRE;
    end else begin
      state   <= state_next;
      rd_slot <= rd_issue ? rd_slot_next : RD_CENTRE;
    end
  end

  // ---------------------------------------------------------------- memory port
  logic [LIN_W-1:0]   mem_lin, nx_l, plane_l;
  logic               addr_ok;
  logic [VOXEL_W-1:0] rdata;

  assign nx_l    = LIN_W'(nx);
  assign plane_l = LIN_W'(plane_q);

  // Neighbours are offsets from the centre: +-1, +-nx, +-nx*ny
  always_comb begin
    case (rd_slot)
      RD_XP:   mem_lin = base_q + LIN_W'(1);
      RD_XM:   mem_lin = base_q - LIN_W'(1);
      RD_YP:   mem_lin = base_q + nx_l;
      RD_YM:   mem_lin = base_q - nx_l;
      RD_ZP:   mem_lin = base_q + plane_l;
      RD_ZM:   mem_lin = base_q - plane_l;
      default: mem_lin = base_q;
    endcase
  end

  // Beyond the memory: writes dropped, reads give zero
  assign addr_ok = (32'(mem_lin) < 32'(VOXEL_DEPTH));
  assign ram_we  = (state == ST_WRITE) && addr_ok;

  vsg_ram #(
    .DEPTH (VOXEL_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (AW'(mem_lin)),
    .wdata (vox_q),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------- read capture
  logic                     cap_valid, cap_oob;
  slot_t                    cap_slot;
  logic [VOXEL_W-1:0]       cap_val, cen_q, plus_q;
  logic signed [GRAD_W-1:0] gx_q, gy_q, gz_q, diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else begin
      cap_valid <= rd_issue;
    end
    cap_slot <= rd_slot;
    cap_oob  <= !addr_ok;
  end

  assign cap_val = cap_oob ? '0 : rdata;
  assign diff    = GRAD_W'({1'b0, plus_q}) - GRAD_W'({1'b0, cap_val});

  // Plus neighbour is held until its minus partner arrives
  always_ff @(posedge clk) begin
    if (cap_valid) begin
      case (cap_slot)
        RD_CENTRE: cen_q <= cap_val;
        RD_XM:     gx_q  <= diff;
        RD_YM:     gy_q  <= diff;
        RD_ZM:     gz_q  <= diff;
        default:   plus_q <= cap_val;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  logic [VOXEL_W-1:0]       out_voxel;
  logic signed [GRAD_W-1:0] out_gx, out_gy, out_gz;
  logic                     out_inside, out_interior;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_out) begin
      out_voxel    <= inside_q ? cen_q : '0;
      out_gx       <= interior_q ? gx_q : '0;
      out_gy       <= interior_q ? gy_q : '0;
      out_gz       <= interior_q ? gz_q : '0;
      out_inside   <= inside_q;
      out_interior <= interior_q;
    end
  end

  assign m_tdata = {5'b0, out_gz, out_gy, out_gx, out_voxel};
  assign m_tuser = {out_interior, out_inside};

  // ---------------------------------------------------------------- assertions
  a_accept_to_mul: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MUL))
    else $error("accepted item did not enter address stage");

  a_capture_follows_read: assert property (@(posedge clk) disable iff (rst)
    cap_valid |-> ($past(state) == ST_READ))
    else $error("read data captured without a read issued");

  a_read_only_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> ((func_q == FUNC_QUERY) && inside_q))
    else $error("memory read for a write or outside point");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_inside) |-> ((out_voxel == '0) && !out_interior))
    else $error("outside query gave non-zero result");

  a_border_zero_grad: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_interior) |-> ((out_gx == '0) && (out_gy == '0) && (out_gz == '0)))
    else $error("non-zero gradient off the interior");

endmodule

[test/voxel_store_central_gradient_core_tb.sv]
// Self-checking bench for voxel_store_central_gradient_core: streams voxel writes and
// gradient queries, predicts each result in-bench and compares it field by field.
// Depends on vsg_pkg and the core RTL only.
`timescale 1ns / 1ps

module voxel_store_central_gradient_core_tb;
  import vsg_pkg::*;

  localparam int MAX_DIM        = DEFAULT_MAX_DIM;
  localparam int VOXEL_DEPTH    = DEFAULT_VOXEL_DEPTH;
  localparam int QUIET_LIMIT    = 2000; // cycles with no handshake at all before giving up
  localparam int DRAIN_CYCLES   = 20;   // lets the last write reach the memory after acceptance
  localparam int END_CYCLES     = 30;
  localparam int RX_HOLD_CYCLES = 300;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [VOXEL_W-1:0] v;
  } voxel_item_t;

  typedef struct packed {
    logic [VOXEL_W-1:0]       voxel;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gz;
    logic                     inside_res;
    logic                     interior;
  } gradient_t;

  // DUT connections; every input known from time zero
  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata  = '0;
  logic                  s_tuser  = FUNC_WRITE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;
  logic [1:0]            m_tuser;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state: its own image of the voxel memory and of the size registers
  bit   [VOXEL_W-1:0] voxel_image [VOXEL_DEPTH];
  logic [SIZE_W-1:0]  cfg_size_x = SIZE_RESET;
  logic [SIZE_W-1:0]  cfg_size_y = SIZE_RESET;
  logic [SIZE_W-1:0]  cfg_size_z = SIZE_RESET;

  voxel_item_t item_queue [$];        // items waiting to be offered
  gradient_t   pending_gradients [$]; // expected query results, oldest first
  voxel_item_t offered;
  int          items_queued   = 0;
  int          items_accepted = 0;
  int          results_taken  = 0;
  int          fail_count     = 0;
  int          quiet_cycles   = 0;
  int          rx_hold_left   = 0;
  bit          rx_hold_req    = 1'b0;
  bit          rx_hold_done   = 1'b0;
  idle_mode_t  idle_mode      = IDLE_NONE;

  voxel_store_central_gradient_core dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sizes above MAX_DIM saturate
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] s);
    return (s > MAX_DIM) ? MAX_DIM : s;
  endfunction

  // Linear address under the current sizes; past the end of memory reads as zero
  function automatic int unsigned voxel_addr(int unsigned x, int unsigned y, int unsigned z);
    return x + eff_size(cfg_size_x) * (y + eff_size(cfg_size_y) * z);
  endfunction

  function automatic logic [VOXEL_W-1:0] stored_voxel(int unsigned x, int unsigned y,
                                                       int unsigned z);
    int unsigned a;
    a = voxel_addr(x, y, z);
    if (a >= VOXEL_DEPTH) return '0;
    return voxel_image[a];
  endfunction

  // 9-bit two's complement difference of two unsigned bytes
  function automatic logic signed [GRAD_W-1:0] central_diff(logic [VOXEL_W-1:0] hi,
                                                            logic [VOXEL_W-1:0] lo);
    int d;
    d = int'(hi) - int'(lo);
    return d[GRAD_W-1:0];
  endfunction

  function automatic bit point_inside(voxel_item_t it);
    return (it.x < eff_size(cfg_size_x)) && (it.y < eff_size(cfg_size_y)) &&
           (it.z < eff_size(cfg_size_z));
  endfunction

  function automatic gradient_t predict_gradient(voxel_item_t it);
    gradient_t   g;
    int unsigned x, y, z;
    g = '0;
    x = it.x;
    y = it.y;
    z = it.z;
    if (!point_inside(it)) return g;
    g.voxel      = stored_voxel(x, y, z);
    g.inside_res = 1'b1;
    if (x > 0 && y > 0 && z > 0 && x + 1 < eff_size(cfg_size_x) &&
        y + 1 < eff_size(cfg_size_y) && z + 1 < eff_size(cfg_size_z)) begin
      g.gx       = central_diff(stored_voxel(x + 1, y, z), stored_voxel(x - 1, y, z));
      g.gy       = central_diff(stored_voxel(x, y + 1, z), stored_voxel(x, y - 1, z));
      g.gz       = central_diff(stored_voxel(x, y, z + 1), stored_voxel(x, y, z - 1));
      g.interior = 1'b1;
    end
    return g;
  endfunction

  // Called at the edge an item is taken: writes update the image, queries queue a result
  task automatic accept_voxel_item(voxel_item_t it);
    int unsigned a;
    if (it.func == FUNC_WRITE) begin
      if (point_inside(it)) begin
        a = voxel_addr(it.x, it.y, it.z);
        if (a < VOXEL_DEPTH) voxel_image[a] = it.v;
      end
    end else begin
      pending_gradients.push_back(predict_gradient(it));
    end
  endtask

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, holds tvalid until taken, random gaps between items
  // ---------------------------------------------------------------------------
  function automatic int unsigned sender_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 47;
      IDLE_BOTH: return 37;
      default:   return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        accept_voxel_item(offered);
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (item_queue.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct()) begin
          offered = item_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'd0, offered.v, offered.z, offered.y, offered.x};
          s_tuser  <= offered.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results, compares with the oldest expectation; random stalls
  // plus one long hold-off once results are flowing, so the core backs up
  // ---------------------------------------------------------------------------
  function automatic int unsigned receiver_stall_pct();
    case (idle_mode)
      IDLE_RECV: return 47;
      IDLE_BOTH: return 37;
      default:   return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    gradient_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_taken++;
        if (pending_gradients.size() == 0) begin
          flag_mismatch("result with none expected", 1, 0);
        end else begin
          want = pending_gradients.pop_front();
          if (m_tdata[7:0] !== want.voxel)
            flag_mismatch("voxel_out", m_tdata[7:0], want.voxel);
          if (m_tdata[16:8] !== want.gx)
            flag_mismatch("grad_x", $signed(m_tdata[16:8]), want.gx);
          if (m_tdata[25:17] !== want.gy)
            flag_mismatch("grad_y", $signed(m_tdata[25:17]), want.gy);
          if (m_tdata[34:26] !== want.gz)
            flag_mismatch("grad_z", $signed(m_tdata[34:26]), want.gz);
          if (m_tuser[0] !== want.inside_res)
            flag_mismatch("inside_res", m_tuser[0], want.inside_res);
          if (m_tuser[1] !== want.interior)
            flag_mismatch("interior", m_tuser[1], want.interior);
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
        m_tready     <= 1'b0;
      end else if (rx_hold_req && !rx_hold_done && m_tvalid) begin
        rx_hold_done <= 1'b1;
        rx_hold_left <= RX_HOLD_CYCLES;
        m_tready     <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= receiver_stall_pct());
      end
    end
  end

  // Watchdog: any handshake on either stream or the APB port counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(logic func, int unsigned x, int unsigned y, int unsigned z,
                           int unsigned v);
    voxel_item_t it;
    it.func = func;
    it.x    = x[COORD_W-1:0];
    it.y    = y[COORD_W-1:0];
    it.z    = z[COORD_W-1:0];
    it.v    = v[VOXEL_W-1:0];
    item_queue.push_back(it);
    items_queued++;
  endtask

  // Everything taken, every result in, and a write's latency allowed for
  task automatic wait_idle();
    wait (items_accepted == items_queued && pending_gradients.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; the register takes the value at the access edge
  task automatic write_size(logic [1:0] which, int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {which, 2'b00};
    pwdata  <= value & 32'h7f;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (which)
      REG_SIZE_X: cfg_size_x = value[SIZE_W-1:0];
      REG_SIZE_Y: cfg_size_y = value[SIZE_W-1:0];
      REG_SIZE_Z: cfg_size_z = value[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_volume(int unsigned sx, int unsigned sy, int unsigned sz);
    wait_idle();
    write_size(REG_SIZE_X, sx);
    write_size(REG_SIZE_Y, sy);
    write_size(REG_SIZE_Z, sz);
  endtask

  // Fill every voxel of the configured volume so no query ever reads an unwritten entry
  task automatic load_volume();
    int unsigned x, y, z;
    for (z = 0; z < eff_size(cfg_size_z); z++)
      for (y = 0; y < eff_size(cfg_size_y); y++)
        for (x = 0; x < eff_size(cfg_size_x); x++)
          push_item(FUNC_WRITE, x, y, z, $urandom_range(255, 0));
  endtask

  // Mostly queries and writes inside the volume; the rest anywhere in the 6-bit space
  task automatic random_items(int n);
    int unsigned pick, x, y, z;
    logic        func;
    bit          any_inside;
    any_inside = eff_size(cfg_size_x) * eff_size(cfg_size_y) * eff_size(cfg_size_z) > 0;
    repeat (n) begin
      pick = $urandom_range(99, 0);
      func = (pick < 75) ? FUNC_QUERY : FUNC_WRITE;
      if (any_inside && (pick < 60 || (pick >= 75 && pick < 95))) begin
        x = $urandom_range(eff_size(cfg_size_x) - 1, 0);
        y = $urandom_range(eff_size(cfg_size_y) - 1, 0);
        z = $urandom_range(eff_size(cfg_size_z) - 1, 0);
      end else begin
        x = $urandom_range(63, 0);
        y = $urandom_range(63, 0);
        z = $urandom_range(63, 0);
      end
      push_item(func, x, y, z, $urandom_range(255, 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: 3x3x3 volume, one interior point, gradients at both extremes
    set_volume(3, 3, 3);
    load_volume();
    push_item(FUNC_WRITE, 2, 1, 1, 255);
    push_item(FUNC_WRITE, 0, 1, 1, 0);
    push_item(FUNC_WRITE, 1, 2, 1, 0);
    push_item(FUNC_WRITE, 1, 0, 1, 255);
    push_item(FUNC_WRITE, 1, 1, 2, 128);
    push_item(FUNC_WRITE, 1, 1, 0, 127);
    push_item(FUNC_WRITE, 1, 1, 1, 200);
    push_item(FUNC_QUERY, 1, 1, 1, 0);     // +255 / -255 / +1
    push_item(FUNC_QUERY, 0, 0, 0, 255);   // corner: border
    push_item(FUNC_QUERY, 2, 2, 2, 0);     // far corner
    push_item(FUNC_QUERY, 2, 1, 1, 0);     // border on x only
    push_item(FUNC_WRITE, 63, 63, 63, 255); // outside: ignored
    push_item(FUNC_QUERY, 63, 63, 63, 255); // outside: all zero
    push_item(FUNC_QUERY, 3, 0, 0, 0);
    push_item(FUNC_QUERY, 0, 3, 0, 0);
    push_item(FUNC_QUERY, 0, 0, 3, 0);
    push_item(FUNC_WRITE, 2, 1, 1, 0);
    push_item(FUNC_WRITE, 0, 1, 1, 255);
    push_item(FUNC_QUERY, 1, 1, 1, 0);     // grad_x now -255

    // Same 27 voxels seen through a reshaped volume without reloading
    set_volume(9, 3, 1);
    random_items(15);

    // The 64 voxels loaded here cover every later volume, which stays at 64 or fewer
    idle_mode = IDLE_SEND;
    set_volume(4, 4, 4);
    load_volume();
    rx_hold_req = 1'b1; // long receiver hold-off once these results start coming
    random_items(100);

    idle_mode = IDLE_RECV;
    set_volume(64, 1, 1);
    random_items(50);

    idle_mode = IDLE_BOTH;
    set_volume(3, 3, 7);
    random_items(50);

    idle_mode = IDLE_NONE;
    set_volume(1, 64, 1);
    random_items(40);

    // Oversized register saturates to MAX_DIM
    idle_mode = IDLE_SEND;
    set_volume(127, 1, 1);
    random_items(40);

    idle_mode = IDLE_RECV;
    set_volume(1, 1, 64);
    random_items(40);

    // Zero size: nothing is inside
    idle_mode = IDLE_BOTH;
    set_volume(0, 5, 5);
    random_items(25);

    for (i = 0; i < 4; i++) begin
      idle_mode = idle_mode_t'(i);
      set_volume($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(4, 1));
      random_items(20);
    end

    wait (items_accepted == items_queued && pending_gradients.size() == 0);
    repeat (END_CYCLES) @(posedge clk);
    if (pending_gradients.size() != 0)
      flag_mismatch("results missing at end", pending_gradients.size(), 0);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/vsg_pkg.sv
hdl/vsg_ram.sv
hdl/voxel_store_central_gradient_core.sv
test/voxel_store_central_gradient_core_tb.sv
